[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL files; wfat_seq includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wfat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wfat_pkg;

  localparam logic       REQ_FRAME         = 1'b0;
  localparam logic       REQ_CLEAR         = 1'b1;
  localparam logic [1:0] FTYPE_MGMT        = 2'd0;
  localparam logic [3:0] SUBTYPE_BEACON    = 4'd8;
  localparam logic [3:0] SUBTYPE_PROBE_REQ = 4'd4;

  typedef logic [47:0] mac_addr_t;

  typedef struct packed {
    logic       req_type;
    logic [1:0] frame_type;
    logic [3:0] frame_subtype;
    mac_addr_t  addr_one;
    mac_addr_t  addr_two;
  } item_t;

  typedef struct packed {
    logic [15:0] frames_seen;
    logic [15:0] kept_frames;
    logic [15:0] probe_count;
    logic [8:0]  distinct_count;
    logic        table_full;
  } result_t;

  // Control from the scan sequencer to the address memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } seq_state_t;

  function automatic logic is_beacon(input item_t it);
    return (it.frame_type == FTYPE_MGMT) && (it.frame_subtype == SUBTYPE_BEACON);
  endfunction

  function automatic logic is_probe_req(input item_t it);
    return (it.frame_type == FTYPE_MGMT) && (it.frame_subtype == SUBTYPE_PROBE_REQ);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/wfat_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module wfat_table import wfat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned IDX_W       = 8
) (
  input  wire logic             clk,
  input  wire tbl_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire mac_addr_t        wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output mac_addr_t             rd_data
);

  mac_addr_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wfat_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wfat_seq import wfat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned IDX_W       = 8,
  parameter int unsigned CNT_W       = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire item_t            item,
  output logic                  busy,
  output logic                  done,
  output logic [CNT_W-1:0]      count,
  output logic                  overflow,
  output tbl_ctl_t              tbl_ctl,
  output logic [IDX_W-1:0]      wr_addr,
  output mac_addr_t             wr_data,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire mac_addr_t        rd_data
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  seq_state_t       state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count_next;
  logic             overflow_next;
  logic             pend, pend_next;
  logic             key_sel, key_sel_next;
  mac_addr_t        addr_a, addr_b;

  logic      accept;
  logic      skip_scan;
  mac_addr_t key;
  logic      hit, more, miss, key_end, room;

  assign accept    = start && (state == ST_IDLE);
  assign skip_scan = (item.req_type == REQ_CLEAR) || is_beacon(item);

  // A pending read returns the entry at idx - 1; the key misses once every
  // entry below the count has been compared without a match.
  assign key     = key_sel ? addr_b : addr_a;
  assign hit     = pend && (rd_data == key);
  assign more    = idx < count;
  assign miss    = !hit && !more;
  assign key_end = (state == ST_SCAN) && (hit || miss);
  assign room    = count < DEPTH_CNT;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = skip_scan ? ST_REPORT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_end && key_sel) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    done          = 1'b0;
    tbl_ctl.rd_en = 1'b0;
    tbl_ctl.wr_en = 1'b0;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN: begin
        tbl_ctl.rd_en = !hit && more;
        tbl_ctl.wr_en = miss && room;
      end
      ST_REPORT: done = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign rd_addr = idx[IDX_W-1:0];
  assign wr_addr = count[IDX_W-1:0];
  assign wr_data = key;

  always_comb begin
    idx_next      = idx;
    pend_next     = pend;
    key_sel_next  = key_sel;
    count_next    = count;
    overflow_next = overflow;
    if (accept) begin
      idx_next     = '0;
      pend_next    = 1'b0;
      key_sel_next = 1'b0;
      if (item.req_type == REQ_CLEAR) begin
        count_next    = '0;
        overflow_next = 1'b0;
      end
    end else if (state == ST_SCAN) begin
      if (key_end) begin
        idx_next     = '0;
        pend_next    = 1'b0;
        key_sel_next = 1'b1;
        if (miss) begin
          if (room) begin
            count_next = count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
        end
      end else begin
        pend_next = 1'b1;
        idx_next  = idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      pend     <= 1'b0;
      key_sel  <= 1'b0;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      pend     <= pend_next;
      key_sel  <= key_sel_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_a <= item.addr_one;
      addr_b <= item.addr_two;
    end
  end

  `ASSERT_SAME(a_count_in_range, clk, rst, 1'b1, count <= DEPTH_CNT, "entry count past depth")
  `ASSERT_SAME(a_write_has_room, clk, rst, tbl_ctl.wr_en, count < DEPTH_CNT, "write into full table")
  `ASSERT_SAME(a_overflow_when_full, clk, rst, $rose(overflow), count == DEPTH_CNT, "overflow below depth")
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy, "result strobe longer than a cycle")

endmodule

`default_nettype wire

[hw/rtl/wifi_frame_address_tally_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                    Transfer
// item in    start, busy, item        accepted when start is high and busy is low
// result     done, result             one-cycle strobe, always taken
//
// A clear request or a management beacon gives its result in the cycle right
// after it is accepted. Any other frame scans the address memory once per
// address, one entry a cycle through its single read port, before its result
// is given. Reset empties the table by zeroing its entry count, and zeroes
// the counters. The receiver cannot stall; busy holds new transactions off.

module wifi_frame_address_tally_core import wfat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             accept;
  logic [15:0]      frames_seen, kept_frames, probe_count;
  logic [CNT_W-1:0] count;
  logic             overflow;
  tbl_ctl_t         tbl_ctl;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  mac_addr_t        wr_data, rd_data;

  assign accept = start && !busy;

  wfat_seq #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .done    (done),
    .count   (count),
    .overflow(overflow),
    .tbl_ctl (tbl_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wfat_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk    (clk),
    .ctl    (tbl_ctl),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
      kept_frames <= '0;
      probe_count <= '0;
    end else if (accept) begin
      if (item.req_type == REQ_CLEAR) begin
        frames_seen <= '0;
        kept_frames <= '0;
        probe_count <= '0;
      end else begin
        frames_seen <= frames_seen + 16'd1;
        if (!is_beacon(item)) begin
          kept_frames <= kept_frames + 16'd1;
        end
        if (is_probe_req(item)) begin
          probe_count <= probe_count + 16'd1;
        end
      end
    end
  end

  assign result.frames_seen    = frames_seen;
  assign result.kept_frames    = kept_frames;
  assign result.probe_count    = probe_count;
  assign result.distinct_count = 9'(count);
  assign result.table_full     = overflow;

endmodule

`default_nettype wire
